FILE: rtl/core/cgvs_pkg.sv
`default_nettype none

package cgvs_pkg;

   localparam int AXES      = 3;
   localparam int AXIS_W    = $clog2(AXES);
   localparam int DATA_W    = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int FILT_W    = 32;
   localparam int GAIN_W    = 32;

   // One shared signed multiplier: 33 x 17 bits gives a 50-bit product.
   localparam int MUL_A_W  = FILT_W + 1;
   localparam int MUL_B_W  = DATA_W + 1;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int FRND_W   = PROD_W - 16;
   localparam int ORND_W   = PROD_W - 32;

   localparam logic [CSR_W-1:0] ALPHA_RESET   = 16'd65208;
   localparam logic [CSR_W-1:0] VMAX_RESET    = 16'd9830;
   localparam logic [CSR_W-1:0] SCALE_RESET   = 16'd46341;
   localparam logic [CSR_W-1:0] TIMEOUT_RESET = 16'd2000;

   typedef logic signed [DATA_W-1:0] sample_type;
   typedef logic signed [FILT_W-1:0] filt_type;

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_TARGET = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_STOP   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA   = 2'd0,
      CSR_VMAX    = 2'd1,
      CSR_SCALE   = 2'd2,
      CSR_TIMEOUT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_GAIN,
      MUL_ALPHA_F,
      MUL_GAIN_T,
      MUL_SCALE_F,
      MUL_STOP_F
   } mul_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAIN,
      ST_AF,
      ST_GT,
      ST_WAIT,
      ST_SF,
      ST_SAF,
      ST_LAST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              accept;
      mul_op_type        mul_op;
      logic [AXIS_W-1:0] axis;
      logic              emit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

   typedef struct {
      cmd_type          cmd;
      sample_type       target [AXES];
      logic [AXES-1:0]  contact;
      logic [AXES-1:0]  collision;
      sample_type       desired [AXES];
   } req_word_type;

endpackage

`default_nettype wire

FILE: rtl/core/cgvs_if.sv
`default_nettype none

interface cgvs_req_if;
   logic                     valid;
   logic                     ready;
   cgvs_pkg::cmd_type        cmd;
   logic signed [15:0]       target_x;
   logic signed [15:0]       target_y;
   logic signed [15:0]       target_z;
   logic [2:0]               contact_mask;
   logic [2:0]               collision_mask;
   logic signed [15:0]       desired_x;
   logic signed [15:0]       desired_y;
   logic signed [15:0]       desired_z;

   modport source (
      output valid, cmd, target_x, target_y, target_z, contact_mask, collision_mask,
             desired_x, desired_y, desired_z,
      input  ready
   );
   modport sink (
      input  valid, cmd, target_x, target_y, target_z, contact_mask, collision_mask,
             desired_x, desired_y, desired_z,
      output ready
   );
endinterface

interface cgvs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] drive_x;
   logic signed [15:0] drive_y;
   logic signed [15:0] drive_z;

   modport source (
      output valid, drive_x, drive_y, drive_z,
      input  ready
   );
   modport sink (
      input  valid, drive_x, drive_y, drive_z,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/core/cgvs_ctrl.sv
`default_nettype none

module cgvs_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire cgvs_pkg::cmd_type        req_cmd,
   output logic                          req_ready,
   output cgvs_pkg::dp_cmd_type          dp_cmd,
   input  wire cgvs_pkg::dp_status_type  dp_status
);
   import cgvs_pkg::*;

   state_type         state_ff, state_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;
   logic              last_axis;

   assign last_axis = (axis_ff == AXIS_W'(AXES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            axis_in = '0;
            if (req_valid) begin
               if (req_cmd == CMD_TICK) begin
                  state_in = ST_GAIN;
               end else if (req_cmd == CMD_STOP) begin
                  state_in = ST_SAF;
               end
            end
         end
         ST_GAIN: state_in = ST_AF;
         ST_AF:   state_in = ST_GT;
         ST_GT:   state_in = ST_WAIT;
         ST_WAIT: state_in = ST_SF;
         ST_SF: begin
            if (last_axis) begin
               state_in = ST_LAST;
            end else begin
               axis_in  = axis_ff + AXIS_W'(1);
               state_in = ST_AF;
            end
         end
         ST_SAF: begin
            if (last_axis) begin
               state_in = ST_LAST;
            end else begin
               axis_in = axis_ff + AXIS_W'(1);
            end
         end
         ST_LAST: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!dp_status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      dp_cmd.accept = 1'b0;
      dp_cmd.mul_op = MUL_NONE;
      dp_cmd.axis   = axis_ff;
      dp_cmd.emit   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            dp_cmd.accept = req_valid;
         end
         ST_GAIN: dp_cmd.mul_op = MUL_GAIN;
         ST_AF:   dp_cmd.mul_op = MUL_ALPHA_F;
         ST_GT:   dp_cmd.mul_op = MUL_GAIN_T;
         ST_SF:   dp_cmd.mul_op = MUL_SCALE_F;
         ST_SAF:  dp_cmd.mul_op = MUL_STOP_F;
         ST_EMIT: dp_cmd.emit   = !dp_status.out_busy;
         default: dp_cmd.mul_op = MUL_NONE;
      endcase
   end

`ifndef SYNTH
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit |-> !dp_status.out_busy)
      else $error("result word loaded while the previous one is still held");

   a_stop_start: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.accept && req_cmd == CMD_STOP) |=> (state_ff == ST_SAF && axis_ff == '0))
      else $error("stopping tick did not start at the first axis");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.mul_op != MUL_NONE) |-> (axis_ff < AXIS_W'(AXES)))
      else $error("axis counter out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/cgvs_datapath.sv
`default_nettype none

module cgvs_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire cgvs_pkg::dp_cmd_type              dp_cmd,
   output cgvs_pkg::dp_status_type                dp_status,
   input  wire cgvs_pkg::req_word_type            req_word,
   input  wire logic                              csr_write_enable,
   input  wire logic [cgvs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [cgvs_pkg::CSR_W-1:0]        csr_write_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output cgvs_pkg::sample_type                   rsp_drive [cgvs_pkg::AXES]
);
   import cgvs_pkg::*;

   localparam logic [16:0] ALPHA_ONE = 17'h10000;
   localparam logic signed [FRND_W-1:0] FILT_MAX = FRND_W'(2**31 - 1);
   localparam logic signed [FRND_W-1:0] FILT_MIN = -(FRND_W'(2**30) <<< 1);
   localparam logic signed [ORND_W-1:0] OUT_MAX  = ORND_W'(32767);
   localparam logic signed [ORND_W-1:0] OUT_MIN  = -ORND_W'(32768);
   localparam logic signed [PROD_W-1:0] RND_F    = PROD_W'(1) <<< 15;
   localparam logic signed [PROD_W-1:0] RND_O    = PROD_W'(1) <<< 31;
   localparam logic signed [FILT_W:0]   RND_S    = (FILT_W + 1)'(1) <<< 15;

   function automatic filt_type sat_filt(input logic signed [FRND_W-1:0] v);
      filt_type r;
      if (v > FILT_MAX) begin
         r = {1'b0, {(FILT_W-1){1'b1}}};
      end else if (v < FILT_MIN) begin
         r = {1'b1, {(FILT_W-1){1'b0}}};
      end else begin
         r = v[FILT_W-1:0];
      end
      return r;
   endfunction

   function automatic sample_type sat_out(input logic signed [ORND_W-1:0] v);
      sample_type r;
      if (v > OUT_MAX) begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v < OUT_MIN) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // Configuration.
   logic [CSR_W-1:0] alpha_ff, vmax_ff, scale_ff, timeout_ff;

   // Block state.
   sample_type        target_ff [AXES];
   filt_type          filt_ff [AXES];
   sample_type        cause_ff [AXES];
   logic              prev_contact_ff;
   logic [DATA_W-1:0] ticks_ff;

   // Per-tick working registers.
   logic [AXES-1:0]             contact_ff;
   logic                        collision_ff;
   logic [GAIN_W-1:0]           gain_ff;
   logic signed [PROD_W-1:0]    acc_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   mul_op_type                  tag_ff;
   logic [AXIS_W-1:0]           tag_axis_ff;
   sample_type                  out_ff [AXES];
   sample_type                  drive_ff [AXES];
   logic                        rsp_valid_ff;

   logic [16:0]                 one_minus_alpha;
   sample_type                  t_sel, t_eff, c_sel;
   filt_type                    f_sel;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]    mul_p;
   logic signed [PROD_W-1:0]    fsum, ssum, csum;
   filt_type                    f_tick, f_stop;
   logic signed [FILT_W:0]      osum;
   sample_type                  o_stop, o_tick;
   logic [DATA_W-1:0]           ticks_in;
   logic                        any_contact;

   assign one_minus_alpha = ALPHA_ONE - {1'b0, alpha_ff};

   // An axis in contact drops its target when target and latched cause agree in sign.
   always_comb begin
      t_sel = target_ff[dp_cmd.axis];
      c_sel = cause_ff[dp_cmd.axis];
      f_sel = filt_ff[dp_cmd.axis];
      t_eff = t_sel;
      if (contact_ff[dp_cmd.axis] &&
          ((t_sel > 0 && c_sel > 0) || (t_sel < 0 && c_sel < 0))) begin
         t_eff = '0;
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (dp_cmd.mul_op)
         MUL_GAIN: begin
            mul_a = {{(MUL_A_W-17){1'b0}}, one_minus_alpha};
            mul_b = {1'b0, vmax_ff};
         end
         MUL_ALPHA_F, MUL_STOP_F: begin
            mul_a = {f_sel[FILT_W-1], f_sel};
            mul_b = {1'b0, alpha_ff};
         end
         MUL_GAIN_T: begin
            mul_a = {1'b0, gain_ff};
            mul_b = {t_eff[DATA_W-1], t_eff};
         end
         MUL_SCALE_F: begin
            mul_a = {f_sel[FILT_W-1], f_sel};
            mul_b = {1'b0, scale_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Writeback arithmetic on the registered product, all round half up.
   always_comb begin
      fsum   = acc_ff + prod_ff + RND_F;
      f_tick = sat_filt(fsum[PROD_W-1:16]);
      ssum   = prod_ff + RND_F;
      f_stop = sat_filt(ssum[PROD_W-1:16]);
      osum   = {f_stop[FILT_W-1], f_stop} + RND_S;
      o_stop = sat_out({osum[FILT_W], osum[FILT_W:16]});
      csum   = prod_ff + RND_O;
      o_tick = collision_ff ? '0 : sat_out(csum[PROD_W-1:32]);
   end

   assign ticks_in    = (ticks_ff == {DATA_W{1'b1}}) ? ticks_ff : ticks_ff + DATA_W'(1);
   assign any_contact = |req_word.contact;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff   <= ALPHA_RESET;
         vmax_ff    <= VMAX_RESET;
         scale_ff   <= SCALE_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_ALPHA:   alpha_ff   <= csr_write_data;
            CSR_VMAX:    vmax_ff    <= csr_write_data;
            CSR_SCALE:   scale_ff   <= csr_write_data;
            CSR_TIMEOUT: timeout_ff <= csr_write_data;
            default:     alpha_ff   <= alpha_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            target_ff[a] <= '0;
            cause_ff[a]  <= '0;
         end
         prev_contact_ff <= 1'b0;
         ticks_ff        <= '0;
      end else if (dp_cmd.accept) begin
         if (req_word.cmd == CMD_TARGET) begin
            for (int a = 0; a < AXES; a++) begin
               target_ff[a] <= req_word.target[a];
            end
            ticks_ff <= '0;
         end else if (req_word.cmd == CMD_TICK) begin
            ticks_ff <= ticks_in;
            if (ticks_in > timeout_ff) begin
               for (int a = 0; a < AXES; a++) begin
                  target_ff[a] <= '0;
               end
            end
            if (!prev_contact_ff && any_contact) begin
               for (int a = 0; a < AXES; a++) begin
                  cause_ff[a] <= req_word.desired[a];
               end
            end
            prev_contact_ff <= any_contact;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.accept && req_word.cmd == CMD_TICK) begin
         contact_ff   <= req_word.contact;
         collision_ff <= |req_word.collision;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            filt_ff[a] <= '0;
         end
      end else if (dp_cmd.accept && req_word.cmd == CMD_START) begin
         for (int a = 0; a < AXES; a++) begin
            filt_ff[a] <= '0;
         end
      end else if (tag_ff == MUL_GAIN_T) begin
         filt_ff[tag_axis_ff] <= f_tick;
      end else if (tag_ff == MUL_STOP_F) begin
         filt_ff[tag_axis_ff] <= f_stop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= MUL_NONE;
      end else begin
         tag_ff <= dp_cmd.mul_op;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= mul_p;
      tag_axis_ff <= dp_cmd.axis;
      case (tag_ff)
         MUL_GAIN:    gain_ff <= prod_ff[GAIN_W:1];
         MUL_ALPHA_F: acc_ff  <= prod_ff;
         MUL_SCALE_F: out_ff[tag_axis_ff] <= o_tick;
         MUL_STOP_F:  out_ff[tag_axis_ff] <= o_stop;
         default:     acc_ff  <= acc_ff;
      endcase
   end

   // Output register: the finished word waits here while the next item is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.emit) begin
         for (int a = 0; a < AXES; a++) begin
            drive_ff[a] <= out_ff[a];
         end
      end
   end

   assign dp_status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive          = drive_ff;

endmodule

`default_nettype wire

FILE: rtl/core/contact_gated_velocity_smoother.sv
// Start and set-target words are taken while idle and give no result.
// A control tick runs on one shared 33x17 multiplier (gain, then
// alpha*f, gain*t and scale*f per axis); a stopping tick runs one alpha*f
// per axis. A new word is taken only after the last result is registered.
// Synchronous active-high reset restores the register defaults and clears
// targets, filter state, contact latch and tick counter.
`default_nettype none

module contact_gated_velocity_smoother (
   input  wire logic                            clock,
   input  wire logic                            reset,
   cgvs_req_if.sink                             req_chan,
   cgvs_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_write_enable,
   input  wire logic [cgvs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [cgvs_pkg::CSR_W-1:0]      csr_write_data
);
   import cgvs_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   req_word_type  req_word;
   sample_type    rsp_drive [AXES];
   logic          req_ready;
   logic          rsp_valid;

   always_comb begin
      req_word.cmd        = req_chan.cmd;
      req_word.target[0]  = req_chan.target_x;
      req_word.target[1]  = req_chan.target_y;
      req_word.target[2]  = req_chan.target_z;
      req_word.contact    = req_chan.contact_mask;
      req_word.collision  = req_chan.collision_mask;
      req_word.desired[0] = req_chan.desired_x;
      req_word.desired[1] = req_chan.desired_y;
      req_word.desired[2] = req_chan.desired_z;
   end

   cgvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   cgvs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .req_word         (req_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_drive        (rsp_drive)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.drive_x = rsp_drive[0];
   assign rsp_chan.drive_y = rsp_drive[1];
   assign rsp_chan.drive_z = rsp_drive[2];

endmodule

`default_nettype wire
